[rtl/core/pkit_pkg.sv]
// Package for the path key interning table: constants, status codes, FNV hash constants.
`default_nettype none
package pkit_pkg;
    localparam int unsigned ENTRIES_DEF      = 256;
    localparam int unsigned BUCKETS_DEF      = 512;
    localparam int unsigned MAX_SEGMENTS_DEF = 16;
    localparam int unsigned SEG_BITS         = 32;
    localparam int unsigned SEG_BYTES        = (SEG_BITS + 7) / 8;
    localparam int unsigned ID_OUT_BITS      = 8;
    localparam logic [31:0] FNV_BASIS        = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME        = 32'h0100_0193;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;
endpackage
`default_nettype wire

[rtl/core/pkit_if.sv]
// Request and response channel interfaces of the interning table.
`default_nettype none
interface pkit_req_if import pkit_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SEG_BITS-1:0] segment;
    logic                last;
    modport source (output valid, req_type, segment, last, input ready);
    modport sink   (input valid, req_type, segment, last, output ready);
endinterface

interface pkit_rsp_if import pkit_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ID_OUT_BITS-1:0] entry_id;
    logic [2:0]             status;
    modport source (output valid, entry_id, status, input ready);
    modport sink   (input valid, entry_id, status, output ready);
endinterface
`default_nettype wire

[rtl/core/path_key_interning_table_core.sv]
// Top level of the path key interning table: FNV-1a hasher, linear prober, entry store.
//
//  channel  | dir | payload                     | notes
//  i_req    | in  | req_type, segment, last     | one segment per transaction
//  o_rsp    | out | entry_id, status            | one transaction per key (on last)
//
// One shared 32x32 multiplier folds one byte a cycle of each segment into the hash.
// On the last segment it reduces the hash mod BUCKETS by reciprocal, then each probed
// bucket is read and checked, an occupied entry's hash and length too, and on a match
// each segment is read and compared; then a decision, a key copy on inserts, and the
// response. After reset a clearing pass empties the bucket table; i_req is not ready.
// One key is in flight at a time; i_req stays low while a response waits on o_rsp.
`default_nettype none
module path_key_interning_table_core import pkit_pkg::*; #(
    parameter int unsigned ENTRIES      = ENTRIES_DEF,
    parameter int unsigned BUCKETS      = BUCKETS_DEF,
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pkit_req_if.sink    i_req,
    pkit_rsp_if.source  o_rsp
);
    localparam int unsigned IDW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned UW  = $clog2(ENTRIES + 1);
    localparam int unsigned IW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned RW  = IW + 1;
    localparam int unsigned KW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned LW  = $clog2(MAX_SEGMENTS + 2);
    localparam int unsigned SAW = (ENTRIES * MAX_SEGMENTS > 1) ?
                                  $clog2(ENTRIES * MAX_SEGMENTS) : 1;
    localparam int unsigned BW  = (SEG_BYTES > 1) ? $clog2(SEG_BYTES) : 1;
    // floor reciprocal: quotient estimate is low by at most one
    localparam int unsigned SH    = 31 + IW;
    localparam logic [31:0] RECIP = 32'((64'd1 << SH) / 64'(BUCKETS));

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_HASH  = 12'b0000_0000_0100,
        S_MOD   = 12'b0000_0000_1000,
        S_BRD   = 12'b0000_0001_0000,
        S_BCHK  = 12'b0000_0010_0000,
        S_ECHK  = 12'b0000_0100_0000,
        S_SRD   = 12'b0000_1000_0000,
        S_SCHK  = 12'b0001_0000_0000,
        S_DEC   = 12'b0010_0000_0000,
        S_COPY  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    // memories
    logic [IDW:0]          bkt_mem  [BUCKETS];
    logic [31:0]           ehash_mem[ENTRIES];
    logic [LW-1:0]         elen_mem [ENTRIES];
    logic [SEG_BITS-1:0]   eseg_mem [ENTRIES * MAX_SEGMENTS];
    logic [SEG_BITS-1:0]   key_buf  [MAX_SEGMENTS];

    t_state              r_state, n_state;
    logic [IW-1:0]       r_clr, n_clr;
    logic [LW-1:0]       r_len, n_len;
    logic [31:0]         r_hash, n_hash;
    logic [SEG_BITS-1:0] r_seg, n_seg;
    logic                r_last, n_last;
    logic                r_intern, n_intern;
    logic [BW-1:0]       r_byte, n_byte;
    logic [4:0]          r_bit, n_bit;
    logic [31:0]         r_quo, n_quo;
    logic [RW-1:0]       r_rem, n_rem;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_probe, n_probe;
    logic [IDW-1:0]      r_id, n_id;
    logic [KW-1:0]       r_si, n_si;
    logic                r_found, n_found;
    logic                r_free, n_free;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic [UW-1:0]       r_used, n_used;
    logic [IDW-1:0]      r_id_out, n_id_out;
    t_status             r_status, n_status;

    logic [IDW:0]        r_bkt_q;
    logic [31:0]         r_eh_q;
    logic [LW-1:0]       r_el_q;
    logic [SEG_BITS-1:0] r_es_q;

    logic                bkt_we;
    logic [IW-1:0]       bkt_addr;
    logic [IDW:0]        bkt_wd;
    logic                ent_we;
    logic                seg_we;
    logic [SAW-1:0]      seg_rd_addr, seg_wr_addr;
    logic [7:0]          hbyte;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         hprod;
    logic                in_acc;

    assign in_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.entry_id = ID_OUT_BITS'(r_id_out);
    assign o_rsp.status = r_status;

    // shared multiplier: hash fold, then quotient estimate, then quotient times BUCKETS
    assign hbyte = 8'(r_seg >> {r_byte, 3'b000});
    assign mul_a = (r_state == S_HASH) ? (r_hash ^ {24'd0, hbyte}) :
                   (r_bit == 5'd1)     ? r_quo : r_hash;
    assign mul_b = (r_state == S_HASH) ? FNV_PRIME :
                   (r_bit == 5'd1)     ? 32'(BUCKETS) : RECIP;
    assign hprod = 64'(mul_a) * 64'(mul_b);
    assign seg_rd_addr = SAW'(SAW'(r_id) * SAW'(MAX_SEGMENTS)) + SAW'(r_si);
    assign seg_wr_addr = SAW'(SAW'(r_used) * SAW'(MAX_SEGMENTS)) + SAW'(r_si);

    always_comb begin
        n_state = r_state;    n_clr = r_clr;         n_len = r_len;
        n_hash = r_hash;      n_seg = r_seg;         n_last = r_last;
        n_intern = r_intern;  n_byte = r_byte;       n_bit = r_bit;
        n_rem = r_rem;        n_idx = r_idx;         n_probe = r_probe;
        n_id = r_id;          n_si = r_si;           n_found = r_found;
        n_free = r_free;      n_free_idx = r_free_idx; n_used = r_used;
        n_id_out = r_id_out;  n_status = r_status;   n_quo = r_quo;
        bkt_we = 1'b0;  bkt_addr = r_idx;  bkt_wd = '0;
        ent_we = 1'b0;  seg_we = 1'b0;
        case (r_state)
            S_CLEAR: begin
                bkt_we = 1'b1;
                bkt_addr = r_clr;
                if (r_clr == IW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_seg = i_req.segment;
                    n_last = i_req.last;
                    n_intern = i_req.req_type;
                    n_byte = '0;
                    if (r_len < LW'(MAX_SEGMENTS)) begin
                        n_len = r_len + 1'b1;
                    end else begin
                        n_len = LW'(MAX_SEGMENTS + 1);
                    end
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                n_hash = hprod[31:0];
                n_byte = r_byte + 1'b1;
                if (r_byte == BW'(SEG_BYTES - 1)) begin
                    n_found = 1'b0;
                    n_free = 1'b0;
                    n_probe = '0;
                    n_rem = '0;
                    n_bit = 5'd2;
                    if (!r_last) begin
                        n_state = S_IDLE;
                    end else if (r_len > LW'(MAX_SEGMENTS)) begin
                        n_status = ST_TOO_LONG;
                        n_id_out = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_bit = r_bit - 1'b1;
                if (r_bit == 5'd2) begin
                    n_quo = 32'(hprod >> SH);
                end else if (r_bit == 5'd1) begin
                    // estimate is low by at most one, so this is below 2*BUCKETS
                    n_rem = RW'(33'(r_hash) - 33'(hprod));
                end else begin
                    n_idx = (r_rem >= RW'(BUCKETS)) ? IW'(r_rem - RW'(BUCKETS)) :
                                                      r_rem[IW-1:0];
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                n_state = S_BCHK;
            end
            S_BCHK: begin
                if (!r_bkt_q[IDW]) begin
                    n_free = 1'b1;
                    n_free_idx = r_idx;
                    n_state = S_DEC;
                end else begin
                    n_id = r_bkt_q[IDW-1:0];
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                if (r_eh_q == r_hash && r_el_q == r_len) begin
                    n_si = '0;
                    n_state = S_SRD;
                end else if (r_probe == IW'(BUCKETS - 1)) begin
                    n_state = S_DEC;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_idx = (r_idx == IW'(BUCKETS - 1)) ? '0 : r_idx + 1'b1;
                    n_state = S_BRD;
                end
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_es_q != key_buf[r_si]) begin
                    if (r_probe == IW'(BUCKETS - 1)) begin
                        n_state = S_DEC;
                    end else begin
                        n_probe = r_probe + 1'b1;
                        n_idx = (r_idx == IW'(BUCKETS - 1)) ? '0 : r_idx + 1'b1;
                        n_state = S_BRD;
                    end
                end else if (LW'(r_si) + 1'b1 == r_len) begin
                    n_found = 1'b1;
                    n_state = S_DEC;
                end else begin
                    n_si = r_si + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_DEC: begin
                n_si = '0;
                if (r_found) begin
                    n_status = ST_FOUND;
                    n_id_out = r_id;
                    n_state = S_OUT;
                end else if (!r_intern) begin
                    n_status = ST_NOT_FOUND;
                    n_id_out = '0;
                    n_state = S_OUT;
                end else if (r_used >= UW'(ENTRIES) || !r_free) begin
                    n_status = ST_FULL;
                    n_id_out = '0;
                    n_state = S_OUT;
                end else begin
                    bkt_we = 1'b1;
                    bkt_addr = r_free_idx;
                    bkt_wd = {1'b1, IDW'(r_used)};
                    ent_we = 1'b1;
                    n_status = ST_INSERTED;
                    n_id_out = IDW'(r_used);
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                seg_we = 1'b1;
                if (LW'(r_si) + 1'b1 == r_len) begin
                    n_used = r_used + 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_si = r_si + 1'b1;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_len = '0;
                    n_hash = FNV_BASIS;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_len <= '0;
            r_hash <= FNV_BASIS;
            r_used <= '0;
            r_found <= 1'b0;
            r_free <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_len <= n_len;
            r_hash <= n_hash;
            r_used <= n_used;
            r_found <= n_found;
            r_free <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;          r_last <= n_last;       r_intern <= n_intern;
        r_byte <= n_byte;        r_bit <= n_bit;         r_rem <= n_rem;
        r_idx <= n_idx;          r_probe <= n_probe;     r_id <= n_id;
        r_si <= n_si;            r_free_idx <= n_free_idx;
        r_id_out <= n_id_out;    r_status <= n_status;   r_quo <= n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && r_len < LW'(MAX_SEGMENTS)) begin
            key_buf[r_len[KW-1:0]] <= i_req.segment;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_addr] <= bkt_wd;
        end
        r_bkt_q <= bkt_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ehash_mem[IDW'(r_used)] <= r_hash;
            elen_mem[IDW'(r_used)] <= r_len;
        end
        r_eh_q <= ehash_mem[r_bkt_q[IDW-1:0]];
        r_el_q <= elen_mem[r_bkt_q[IDW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            eseg_mem[seg_wr_addr] <= key_buf[r_si];
        end
        r_es_q <= eseg_mem[seg_rd_addr];
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request ready while a response is pending");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(ENTRIES))
        else $error("entry count beyond capacity");
    a_key_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> (r_len == '0 && r_hash == FNV_BASIS))
        else $error("key collector not cleared after response");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready && o_rsp.status == ST_INSERTED)
        |-> (r_used != '0))
        else $error("insert reported without entry allocation");
`endif
endmodule
`default_nettype wire
